### hdl/slot_pool_allocator_core_defines.svh
// Assertion macros used by the slot pool allocator checker.
`ifndef SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/spa_pkg.sv
// Shared codes, field widths and control structs of the slot pool allocator.
package spa_pkg;

    // Fixed widths of the interface fields.
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 3;
    localparam int SLOT_FIELD_W  = 6;
    localparam int COUNT_FIELD_W = 7;

    // Slot count in use after reset, before it is capped to the pool size.
    localparam int SLOT_COUNT_RESET = 64;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes.
    localparam t_op OP_PLACE  = 3'd0;
    localparam t_op OP_EVICT  = 3'd1;
    localparam t_op OP_POP    = 3'd2;
    localparam t_op OP_PEEK   = 3'd3;
    localparam t_op OP_LOOKUP = 3'd4;

    // Status codes.
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_SLOT = 3'd1;
    localparam t_status ST_OCCUPIED = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_RESIDENT = 3'd4;

    // Commands to the slot table.
    typedef struct packed {
        logic set_occ;
        logic clr_occ;
        logic clr_all;
    } t_tbl_cmd;

    // Commands to the free-order memory.
    typedef struct packed {
        logic wr;
        logic clr_all;
    } t_ord_cmd;

endpackage

### hdl/spa_slot_table.sv
// Per-slot occupied flags and resident node memory with a registered scan read.
module spa_slot_table
    import spa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int NW    = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_cmd      i_cmd,
    input  logic [AW-1:0] i_waddr,
    input  logic [NW-1:0] i_wnode,
    input  logic [AW-1:0] i_qaddr,
    output logic          o_q_occ,
    input  logic [AW-1:0] i_raddr,
    output logic [NW-1:0] o_rd_node,
    output logic          o_rd_occ
);

    logic [DEPTH-1:0] r_occ;
    logic [NW-1:0]    r_mem [DEPTH];
    logic [NW-1:0]    r_rd_node;
    logic             r_rd_occ;

    // Occupied flags clear at once on reset or on a slot count write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.clr_all) begin
            r_occ <= '0;
        end else if (i_cmd.set_occ) begin
            r_occ[i_waddr] <= 1'b1;
        end else if (i_cmd.clr_occ) begin
            r_occ[i_waddr] <= 1'b0;
        end
    end

    // Node memory: one write port, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_occ) begin
            r_mem[i_waddr] <= i_wnode;
        end
        r_rd_node <= r_mem[i_raddr];
        r_rd_occ  <= r_occ[i_raddr];
    end

    assign o_q_occ   = r_occ[i_qaddr];
    assign o_rd_node = r_rd_node;
    assign o_rd_occ  = r_rd_occ;

endmodule

### hdl/spa_order_ram.sv
// Free-order memory; entries not written since the last rebuild read as their own index.
module spa_order_ram
    import spa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ord_cmd      i_cmd,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [DEPTH-1:0] r_vld;
    logic [AW-1:0]    r_mem [DEPTH];
    logic [AW-1:0]    r_rd_data;
    logic [AW-1:0]    r_rd_addr;
    logic             r_rd_vld;

    // One written flag per entry, cleared together on a rebuild.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr_all) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Storage with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
        r_rd_addr <= i_raddr;
        r_rd_vld  <= r_vld[i_raddr];
    end

    // An entry untouched since the rebuild holds its own index.
    assign o_rdata = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule

### hdl/slot_pool_allocator_core.sv
// Top level of the slot pool allocator: sequencer, shared comparator and free-list bookkeeping.
//
//  Channel   Handshake                       Word
//  -------   -----------------------------   ------------------------------------------
//  command   start, busy                     i_operation, i_node_id, i_slot_index
//  result    o_result_valid (strobe)         o_status, o_result_slot, o_found, o_free_count
//  config    i_cfg_valid, o_cfg_ready        i_cfg_data (slot count)
//
//  Evict, place into an invalid or occupied slot, pop or peek of an empty list and unknown
//  operations answer in the cycle after start is taken; other pops and peeks first read the
//  free-order memory. A lookup miss runs a scan of the node memory, and a successful place
//  scans the node memory and then the free-order memory, both one entry a cycle through a
//  single shared comparator.
//  Reset is synchronous and active low; it restores slot_count = min(MAX_SLOTS, 64) and a full free list
//  with no clearing pass. The result strobe lasts one cycle and cannot be stalled.
module slot_pool_allocator_core
    import spa_pkg::*;
#(
    parameter int MAX_SLOTS    = 64,
    parameter int NODE_ID_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [NODE_ID_BITS-1:0]  i_node_id,
    input  logic [SLOT_FIELD_W-1:0]  i_slot_index,
    output logic                     o_result_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_FIELD_W-1:0]  o_result_slot,
    output logic                     o_found,
    output logic [COUNT_FIELD_W-1:0] o_free_count,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [COUNT_FIELD_W-1:0] i_cfg_data
);

    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int WIDE_W    = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;
    localparam int CMP_W     = (NODE_ID_BITS > SLOT_W) ? NODE_ID_BITS : SLOT_W;
    localparam int RST_SLOTS = (MAX_SLOTS < SLOT_COUNT_RESET) ? MAX_SLOTS : SLOT_COUNT_RESET;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NSCAN,
        S_FSCAN,
        S_RD
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_busy;
    t_op                       r_op, n_op;
    logic [NODE_ID_BITS-1:0]   r_node, n_node;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [SLOT_W-1:0]         r_prev, n_prev;
    logic                      r_pend, n_pend;
    logic                      r_seen, n_seen;
    logic [CNT_W-1:0]          r_slot_count, n_slot_count;
    logic [CNT_W-1:0]          r_free_total, n_free_total;
    logic                      r_res_valid, n_res_valid;
    t_status                   r_status, n_status;
    logic [SLOT_FIELD_W-1:0]   r_rslot, n_rslot;
    logic                      r_found, n_found;

    logic                      acc;
    logic                      cfg_acc;
    logic                      bad_slot;
    logic [SLOT_W-1:0]         slot_a;
    logic [SLOT_W-1:0]         rd_a;
    logic                      issue;
    logic [WIDE_W-1:0]         cfg_w;
    logic [WIDE_W-1:0]         cfg_clamped;

    t_tbl_cmd                  tbl_cmd;
    logic [SLOT_W-1:0]         tbl_waddr;
    logic                      q_occ;
    logic [NODE_ID_BITS-1:0]   tbl_rd_node;
    logic                      tbl_rd_occ;

    t_ord_cmd                  ord_cmd;
    logic [SLOT_W-1:0]         ord_waddr;
    logic [SLOT_W-1:0]         ord_wdata;
    logic [SLOT_W-1:0]         ord_rd;

    logic [CMP_W-1:0]          cmp_a;
    logic [CMP_W-1:0]          cmp_b;
    logic                      cmp_eq;

    // Handshakes.
    assign acc         = start && !r_busy;
    assign o_cfg_ready = !r_busy && !start;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // Command slot checks.
    assign bad_slot = WIDE_W'(i_slot_index) >= WIDE_W'(r_slot_count);
    assign slot_a   = SLOT_W'(i_slot_index);
    assign rd_a     = r_idx[SLOT_W-1:0];

    // Slot count clamp to 1..MAX_SLOTS.
    assign cfg_w       = WIDE_W'(i_cfg_data);
    assign cfg_clamped = (cfg_w == '0) ? WIDE_W'(1) :
                         (cfg_w > WIDE_W'(MAX_SLOTS)) ? WIDE_W'(MAX_SLOTS) : cfg_w;

    // Shared comparator: node id during the node scan, slot number during the list scan.
    assign cmp_a  = (r_state == S_NSCAN) ? CMP_W'(tbl_rd_node) : CMP_W'(ord_rd);
    assign cmp_b  = (r_state == S_NSCAN) ? CMP_W'(r_node) : CMP_W'(r_slot);
    assign cmp_eq = (cmp_a == cmp_b);

    // Write ports: the idle cycle serves evict, busy cycles serve place.
    assign tbl_waddr = r_busy ? r_slot : slot_a;
    assign ord_waddr = r_busy ? SLOT_W'(r_prev - 1'b1) : r_free_total[SLOT_W-1:0];
    assign ord_wdata = r_busy ? ord_rd : slot_a;

    // Read issue: one entry a cycle while the scan range lasts.
    always_comb begin
        unique case (r_state)
            S_NSCAN: issue = r_idx < r_slot_count;
            S_FSCAN: issue = r_idx < r_free_total;
            S_RD:    issue = !r_pend;
            default: issue = 1'b0;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_node       = r_node;
        n_slot       = r_slot;
        n_idx        = issue ? r_idx + 1'b1 : r_idx;
        n_prev       = r_idx[SLOT_W-1:0];
        n_pend       = issue;
        n_seen       = r_seen;
        n_slot_count = r_slot_count;
        n_free_total = r_free_total;
        n_res_valid  = 1'b0;
        n_status     = ST_OK;
        n_rslot      = '0;
        n_found      = 1'b0;
        tbl_cmd      = '0;
        ord_cmd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_slot_count    = CNT_W'(cfg_clamped);
                    n_free_total    = CNT_W'(cfg_clamped);
                    tbl_cmd.clr_all = 1'b1;
                    ord_cmd.clr_all = 1'b1;
                end else if (acc) begin
                    n_op   = i_operation;
                    n_node = i_node_id;
                    n_slot = slot_a;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_seen = 1'b0;
                    unique case (i_operation)
                        OP_PLACE: begin
                            if (bad_slot) begin
                                n_res_valid = 1'b1;
                                n_status    = ST_BAD_SLOT;
                            end else if (q_occ) begin
                                n_res_valid = 1'b1;
                                n_status    = ST_OCCUPIED;
                            end else begin
                                n_state = S_NSCAN;
                            end
                        end
                        OP_EVICT: begin
                            n_res_valid = 1'b1;
                            if (bad_slot) begin
                                n_status = ST_BAD_SLOT;
                            end else if (q_occ) begin
                                tbl_cmd.clr_occ = 1'b1;
                                if (r_free_total < MAX_CNT) begin
                                    ord_cmd.wr   = 1'b1;
                                    n_free_total = r_free_total + 1'b1;
                                end
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_free_total == '0) begin
                                n_res_valid = 1'b1;
                                n_status    = ST_EMPTY;
                            end else begin
                                n_state = S_RD;
                                n_idx   = r_free_total - 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            n_state = S_NSCAN;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_NSCAN: begin
                if (r_pend && tbl_rd_occ && cmp_eq) begin
                    // Node found in an occupied slot.
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    if (r_op == OP_LOOKUP) begin
                        n_found = 1'b1;
                        n_rslot = SLOT_FIELD_W'(r_prev);
                    end else begin
                        n_status = ST_RESIDENT;
                    end
                end else if (!r_pend && !issue) begin
                    // Scan ran out without a match.
                    if (r_op == OP_LOOKUP) begin
                        n_state     = S_IDLE;
                        n_res_valid = 1'b1;
                    end else begin
                        tbl_cmd.set_occ = 1'b1;
                        n_state         = S_FSCAN;
                        n_idx           = '0;
                        n_seen          = 1'b0;
                    end
                end
            end

            S_FSCAN: begin
                if (r_pend) begin
                    // Entries behind the placed slot move down by one.
                    if (r_seen) begin
                        ord_cmd.wr = 1'b1;
                    end else if (cmp_eq) begin
                        n_seen = 1'b1;
                    end
                end else if (!issue) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    if (r_seen) begin
                        n_free_total = r_free_total - 1'b1;
                    end
                end
            end

            S_RD: begin
                if (r_pend) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_rslot     = SLOT_FIELD_W'(ord_rd);
                    if (r_op == OP_POP) begin
                        n_free_total = r_free_total - 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_seen       <= 1'b0;
            r_slot_count <= CNT_W'(RST_SLOTS);
            r_free_total <= CNT_W'(RST_SLOTS);
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy       <= (n_state != S_IDLE);
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_seen       <= n_seen;
            r_slot_count <= n_slot_count;
            r_free_total <= n_free_total;
            r_res_valid  <= n_res_valid;
            r_op         <= n_op;
            r_node       <= n_node;
            r_slot       <= n_slot;
            r_prev       <= n_prev;
            r_status     <= n_status;
            r_rslot      <= n_rslot;
            r_found      <= n_found;
        end
    end

    // Slot table: occupied flags and resident node ids.
    spa_slot_table #(
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W),
        .NW    (NODE_ID_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tbl_cmd),
        .i_waddr   (tbl_waddr),
        .i_wnode   (r_node),
        .i_qaddr   (slot_a),
        .o_q_occ   (q_occ),
        .i_raddr   (rd_a),
        .o_rd_node (tbl_rd_node),
        .o_rd_occ  (tbl_rd_occ)
    );

    // Free-order memory.
    spa_order_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W)
    ) u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ord_cmd),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (rd_a),
        .o_rdata (ord_rd)
    );

    assign busy           = r_busy;
    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_result_slot  = r_rslot;
    assign o_found        = r_found;
    assign o_free_count   = COUNT_FIELD_W'(r_free_total);

endmodule

### hdl/spa_checker.sv
// Port-level checker for the slot pool allocator, bound to the top level.
`include "slot_pool_allocator_core_defines.svh"

module spa_checker
    import spa_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_result_valid,
    input logic [STATUS_W-1:0]      o_status,
    input logic [COUNT_FIELD_W-1:0] o_free_count
);

    // Every result word traces back to an accepted command or a running one.
    `SPA_ASSERT_NOW(a_result_has_cmd, i_clk, i_rst_n, o_result_valid, $past(start) || $past(busy), "result word without a command")

    // The sequencer only goes idle by delivering its result.
    `SPA_ASSERT_NOW(a_busy_ends_with_result, i_clk, i_rst_n, $fell(busy), o_result_valid, "busy dropped without a result word")

    // An accepted command either answers at once or starts a multi-cycle run.
    `SPA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_result_valid, "accepted command made no progress")

    // An empty free list is reported with a zero free count.
    `SPA_ASSERT_NOW(a_empty_zero_count, i_clk, i_rst_n, o_result_valid && (o_status == ST_EMPTY), o_free_count == '0, "empty status with nonzero free count")

endmodule

bind slot_pool_allocator_core spa_checker u_spa_checker (.*);

### verif/tb_slot_pool_allocator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the slot pool allocator core, with a built-in slot pool predictor.
module tb_slot_pool_allocator_core;
    import spa_pkg::*;

    localparam int POOL          = 64;
    localparam int NODE_W        = 32;
    localparam int SETTLE_CYCLES = 2 * POOL + 16;
    localparam int DRAIN_LIMIT   = 4 * POOL + 64;
    localparam int TIMEOUT_NS    = 12_000_000;
    localparam int PHASE_ITEMS   = 185;

    // One result word as the block reports it.
    typedef struct packed {
        t_status                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic                     found;
        logic [COUNT_FIELD_W-1:0] free_count;
    } t_reply;

    // Tracks the slot pool and the replies still owed by the block.
    class slot_pool_tracker;
        int unsigned             slot_count;
        bit                      occupied [POOL];
        logic [NODE_W-1:0]       resident_node [POOL];
        logic [SLOT_FIELD_W-1:0] free_order [POOL];
        int unsigned             free_total;
        t_reply                  expected_replies [$];
        int unsigned             mismatch_count;
        int unsigned             reply_count;

        function new();
            mismatch_count = 0;
            reply_count    = 0;
            apply_slot_count(COUNT_FIELD_W'(SLOT_COUNT_RESET));
        endfunction

        // A slot count write clamps the value, clears residency and rebuilds the free list.
        function void apply_slot_count(logic [COUNT_FIELD_W-1:0] value);
            int unsigned n;
            n = 32'(value);
            if (n < 1) n = 1;
            if (n > POOL) n = POOL;
            slot_count = n;
            for (int i = 0; i < POOL; i++) begin
                occupied[i]   = 1'b0;
                free_order[i] = SLOT_FIELD_W'(i);
            end
            free_total = n;
        endfunction

        // Returns the occupied slot holding the node, or POOL when there is none.
        function int unsigned find_resident(logic [NODE_W-1:0] node);
            for (int unsigned i = 0; i < slot_count; i++) begin
                if (occupied[i] && resident_node[i] == node) return i;
            end
            return POOL;
        endfunction

        // Picks a slot in range that is occupied or free as asked, or -1 if none is.
        function int pick_slot(bit want_occupied);
            int unsigned base;
            int unsigned idx;
            base = $urandom_range(0, slot_count - 1);
            for (int unsigned k = 0; k < slot_count; k++) begin
                idx = (base + k) % slot_count;
                if (occupied[idx] == want_occupied) return int'(idx);
            end
            return -1;
        endfunction

        // Applies one accepted command word and queues the reply it must produce.
        function void note_command(t_op op, logic [NODE_W-1:0] node,
                                   logic [SLOT_FIELD_W-1:0] slot);
            t_reply      reply;
            int unsigned pos;
            int unsigned hit;
            reply = '0;
            reply.status = ST_OK;
            case (op)
                OP_PLACE: begin
                    if (slot >= slot_count) begin
                        reply.status = ST_BAD_SLOT;
                    end else if (occupied[slot]) begin
                        reply.status = ST_OCCUPIED;
                    end else if (find_resident(node) < POOL) begin
                        reply.status = ST_RESIDENT;
                    end else begin
                        occupied[slot]      = 1'b1;
                        resident_node[slot] = node;
                        // A popped slot is no longer listed, so the list may stay as it is.
                        pos = free_total;
                        for (int unsigned i = 0; i < free_total; i++) begin
                            if (free_order[i] == slot) begin
                                pos = i;
                                break;
                            end
                        end
                        if (pos < free_total) begin
                            for (int unsigned j = pos; j + 1 < free_total; j++)
                                free_order[j] = free_order[j + 1];
                            free_total--;
                        end
                    end
                end
                OP_EVICT: begin
                    if (slot >= slot_count) begin
                        reply.status = ST_BAD_SLOT;
                    end else if (occupied[slot]) begin
                        occupied[slot] = 1'b0;
                        if (free_total < POOL) begin
                            free_order[free_total] = slot;
                            free_total++;
                        end
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (free_total == 0) begin
                        reply.status = ST_EMPTY;
                    end else begin
                        reply.slot = free_order[free_total - 1];
                        if (op == OP_POP) free_total--;
                    end
                end
                OP_LOOKUP: begin
                    hit = find_resident(node);
                    if (hit < POOL) begin
                        reply.slot  = SLOT_FIELD_W'(hit);
                        reply.found = 1'b1;
                    end
                end
                default: begin
                    // Unknown operations change nothing.
                end
            endcase
            reply.free_count = COUNT_FIELD_W'(free_total);
            expected_replies = {expected_replies, reply};
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        // Compares one result word with the oldest reply still owed.
        task check_reply(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
                return;
            end
            want = expected_replies.pop_front();
            if (got !== want)
                report_mismatch($sformatf(
                    "reply %0d: status %0d/%0d slot %0d/%0d found %0b/%0b free %0d/%0d",
                    reply_count, got.status, want.status, got.slot, want.slot,
                    got.found, want.found, got.free_count, want.free_count));
            reply_count++;
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_op                      i_operation;
    logic [NODE_W-1:0]        i_node_id;
    logic [SLOT_FIELD_W-1:0]  i_slot_index;
    logic                     o_result_valid;
    t_status                  o_status;
    logic [SLOT_FIELD_W-1:0]  o_result_slot;
    logic                     o_found;
    logic [COUNT_FIELD_W-1:0] o_free_count;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [COUNT_FIELD_W-1:0] i_cfg_data;

    slot_pool_tracker  pool_model;
    logic [NODE_W-1:0] node_ids [16];
    bit                gaps_off;

    slot_pool_allocator_core #(
        .MAX_SLOTS    (POOL),
        .NODE_ID_BITS (NODE_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_node_id      (i_node_id),
        .i_slot_index   (i_slot_index),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_found        (o_found),
        .o_free_count   (o_free_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock of 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every result word is checked at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_result_valid) begin
            got.status     = o_status;
            got.slot       = o_result_slot;
            got.found      = o_found;
            got.free_count = o_free_count;
            pool_model.check_reply(got);
        end
    end

    // Holds a command word until the block takes it, then maybe idles for a while.
    task automatic issue_command(t_op op, logic [NODE_W-1:0] node,
                                 logic [SLOT_FIELD_W-1:0] slot);
        start        <= 1'b1;
        i_operation  <= op;
        i_node_id    <= node;
        i_slot_index <= slot;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pool_model.note_command(op, node, slot);
        if (!gaps_off && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 3)) @(posedge i_clk);
            else repeat ($urandom_range(4, 2 * POOL + 12)) @(posedge i_clk);
        end
    endtask

    // Stops sending until every owed reply has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pool_model.expected_replies.size() != 0);
    endtask

    // Writes the slot count while the block is idle.
    task automatic write_slot_count(logic [COUNT_FIELD_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        pool_model.apply_slot_count(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Node ids mostly come from a small set so that places and lookups collide.
    function automatic logic [NODE_W-1:0] random_node();
        if ($urandom_range(0, 99) < 75) return node_ids[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Random commands, mostly aimed at slots and nodes that make the operation do work.
    task automatic run_random_items(int unsigned count);
        int unsigned             pick;
        int unsigned             sel;
        int                      chosen;
        t_op                     op;
        logic [NODE_W-1:0]       node;
        logic [SLOT_FIELD_W-1:0] slot;
        for (int unsigned n = 0; n < count; n++) begin
            pick   = $urandom_range(0, 99);
            sel    = $urandom_range(0, 99);
            node   = random_node();
            slot   = SLOT_FIELD_W'($urandom_range(0, 63));
            chosen = -1;
            if (pick < 30) begin
                op = OP_PLACE;
                if (sel < 70) chosen = pool_model.pick_slot(1'b0);
                else if (sel < 85) chosen = pool_model.pick_slot(1'b1);
            end else if (pick < 50) begin
                op = OP_EVICT;
                if (sel < 60) chosen = pool_model.pick_slot(1'b1);
            end else if (pick < 63) begin
                op = OP_POP;
            end else if (pick < 73) begin
                op = OP_PEEK;
            end else if (pick < 95) begin
                op = OP_LOOKUP;
                if (sel < 60) begin
                    chosen = pool_model.pick_slot(1'b1);
                    if (chosen >= 0) node = pool_model.resident_node[chosen];
                    chosen = -1;
                end
            end else if (pick < 98) begin
                op   = t_op'($urandom_range(OP_LOOKUP + 1, 7));
                node = $urandom;
            end else begin
                op   = t_op'($urandom_range(0, 7));
                node = $urandom;
            end
            if (chosen >= 0) slot = SLOT_FIELD_W'(chosen);
            if ($urandom_range(0, 199) == 0) wait_drained();
            issue_command(op, node, slot);
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several slot counts.
    initial begin
        logic [COUNT_FIELD_W-1:0] plan [8];
        pool_model = new();
        node_ids[0] = '0;
        node_ids[1] = '1;
        for (int i = 2; i < 16; i++) node_ids[i] = $urandom;
        plan = '{7'd127, 7'd1, 7'd64, 7'd2, 7'd65, 7'd33, 7'd0, 7'd8};
        plan[7] = COUNT_FIELD_W'($urandom_range(3, 63));
        gaps_off     = 1'b0;
        start        <= 1'b0;
        i_operation  <= OP_PLACE;
        i_node_id    <= '0;
        i_slot_index <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full pool after reset: place checks, lookups, pops and evicts of popped slots.
        issue_command(OP_PEEK, '0, '0);
        issue_command(OP_PLACE, '0, 6'd0);
        issue_command(OP_PLACE, '1, 6'd63);
        issue_command(OP_PLACE, 32'h1234_5678, 6'd0);
        issue_command(OP_PLACE, '0, 6'd5);
        issue_command(OP_LOOKUP, '1, '0);
        issue_command(OP_LOOKUP, 32'h0BAD_CAFE, '0);
        issue_command(OP_POP, '0, '0);
        issue_command(OP_PLACE, 32'h5A5A_A5A5, 6'd62);
        issue_command(OP_EVICT, '0, 6'd62);
        issue_command(OP_EVICT, '0, 6'd10);
        issue_command(OP_POP, '0, '0);
        issue_command(OP_EVICT, '0, 6'd62);
        for (int k = OP_LOOKUP + 1; k <= 7; k++) issue_command(t_op'(k), '1, '1);

        // A zero slot count becomes one: invalid slots, an empty list, a popped slot placed.
        write_slot_count('0);
        issue_command(OP_PLACE, 32'd1, 6'd1);
        issue_command(OP_EVICT, '0, 6'd63);
        issue_command(OP_POP, '0, '0);
        issue_command(OP_PEEK, '0, '0);
        issue_command(OP_POP, '0, '0);
        issue_command(OP_PLACE, 32'd9, 6'd0);
        issue_command(OP_LOOKUP, 32'd9, '0);
        issue_command(OP_EVICT, '0, 6'd0);

        // Random phases; one of them runs with no sender gaps at all.
        for (int p = 0; p < 8; p++) begin
            write_slot_count(plan[p]);
            gaps_off = (p == 2);
            run_random_items(PHASE_ITEMS);
        end

        // Let the last replies arrive, then watch for stray strobes.
        start <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && pool_model.expected_replies.size() != 0; c++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pool_model.expected_replies.size() != 0)
            pool_model.report_mismatch($sformatf("%0d replies never arrived",
                                                 pool_model.expected_replies.size()));
        if (pool_model.mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

endmodule
